>>> src/eeit_pkg.sv
// Package: payload structs, register indexes and constants for the epipolar error unit.
package eeit_pkg;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
  } eeit_in_t;

  typedef struct packed {
    logic [31:0] epipolar_error;
    logic        is_inlier;
    logic        degenerate;
  } eeit_out_t;

  typedef enum logic [1:0] {
    REG_ROW0      = 2'd0,
    REG_ROW1      = 2'd1,
    REG_ROW2      = 2'd2,
    REG_THRESHOLD = 2'd3
  } eeit_reg_e;

  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 48;
  localparam int unsigned QUOT_W         = 32;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUOT_W / BITS_PER_STAGE;
  localparam logic [31:0] ERR_MAX        = 32'hFFFF_FFFF;
  localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

endpackage

>>> src/epipolar_error_inlier_test_unit.sv
// Top level: pipelined symmetric epipolar error and inlier test.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (eeit_in_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (eeit_out_t)
//  cfg     | input     | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
// One item enters per cycle while in_ready_o is high; a transfer passes through six
// arithmetic stages, then a restoring divider of 16 stages retiring two quotient bits
// each, then the output register. The divider sets the depth.
// Reset clears the matrix, the threshold and all stage valid bits.
// Each stage holds while the next one is full and stalled, so bubbles close up and a
// stalled output does not block input until every stage is full.
module epipolar_error_inlier_test_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [eeit_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [eeit_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  eeit_pkg::eeit_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output eeit_pkg::eeit_out_t                 out_data_o
);

  localparam int unsigned DIVS = eeit_pkg::DIV_STAGES;
  localparam int unsigned NST  = 6 + DIVS + 1;
  localparam int unsigned BPS  = eeit_pkg::BITS_PER_STAGE;

  // divider stage contents, two dividers side by side
  typedef struct packed {
    logic [41:0] r1;
    logic [41:0] r2;
    logic [40:0] n1;
    logic [40:0] n2;
    logic [31:0] q1;
    logic [31:0] q2;
    logic [31:0] dlo;
    logic        sat1;
    logic        sat2;
    logic        degen;
  } div_t;

  function automatic logic [19:0] round_line(input logic signed [33:0] v);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : 34'(v);
    m = m + 34'd2048;
    return m[31:12];
  endfunction

  function automatic div_t div_step(input div_t s);
    div_t t;
    t = s;
    for (int b = 0; b < BPS; b++) begin
      t.r1  = {t.r1[40:0], t.dlo[31]};
      t.r2  = {t.r2[40:0], t.dlo[31]};
      t.dlo = {t.dlo[30:0], 1'b0};
      if (t.r1 >= 42'(t.n1)) begin
        t.r1 = t.r1 - 42'(t.n1);
        t.q1 = {t.q1[30:0], 1'b1};
      end else begin
        t.q1 = {t.q1[30:0], 1'b0};
      end
      if (t.r2 >= 42'(t.n2)) begin
        t.r2 = t.r2 - 42'(t.n2);
        t.q2 = {t.q2[30:0], 1'b1};
      end else begin
        t.q2 = {t.q2[30:0], 1'b0};
      end
    end
    return t;
  endfunction

  // configuration
  logic signed [15:0] f_q [3][3];
  logic [31:0]        thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          f_q[i][j] <= '0;
        end
      end
      thr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (eeit_pkg::eeit_reg_e'(cfg_idx_i))
        eeit_pkg::REG_ROW0, eeit_pkg::REG_ROW1, eeit_pkg::REG_ROW2: begin
          for (int j = 0; j < 3; j++) begin
            f_q[cfg_idx_i][j] <= cfg_wdata_i[16*j +: 16];
          end
        end
        eeit_pkg::REG_THRESHOLD: thr_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // stage flow control: a stage moves when empty or when its successor moves
  logic [NST-1:0] v_q;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NST-1];

  // stage 1: all matrix products
  logic signed [15:0] p1 [3];
  logic signed [15:0] p2 [3];
  logic signed [31:0] lp_d [3][3];
  logic signed [31:0] mp_d [3][3];
  logic signed [31:0] lp_q [3][3];
  logic signed [31:0] mp_q [3][3];
  logic signed [15:0] p2s1_q [3];

  always_comb begin
    p1[0] = in_data_i.first_x;
    p1[1] = in_data_i.first_y;
    p1[2] = eeit_pkg::ONE_Q12;
    p2[0] = in_data_i.second_x;
    p2[1] = in_data_i.second_y;
    p2[2] = eeit_pkg::ONE_Q12;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lp_d[i][j] = f_q[i][j] * p1[j];
        mp_d[i][j] = f_q[i][j] * p2[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      lp_q   <= lp_d;
      mp_q   <= mp_d;
      p2s1_q <= p2;
    end
  end

  // stage 2: line sums l = F*x1, m = F'*x2
  logic signed [33:0] ln_q [3];
  logic signed [33:0] lm_q [3];
  logic signed [15:0] p2s2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        ln_q[i] <= 34'(lp_q[i][0]) + 34'(lp_q[i][1]) + 34'(lp_q[i][2]);
        lm_q[i] <= 34'(mp_q[0][i]) + 34'(mp_q[1][i]) + 34'(mp_q[2][i]);
      end
      p2s2_q <= p2s1_q;
    end
  end

  // stage 3: residual products, rounded line normals
  logic signed [49:0] ep_q [3];
  logic [19:0]        a0_q, a1_q, b0_q, b1_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        ep_q[i] <= p2s2_q[i] * ln_q[i];
      end
      a0_q <= round_line(ln_q[0]);
      a1_q <= round_line(ln_q[1]);
      b0_q <= round_line(lm_q[0]);
      b1_q <= round_line(lm_q[1]);
    end
  end

  // stage 4: residual sum and rounding, squared normal components
  logic signed [51:0] e_sum;
  logic [51:0]        e_mag;
  logic [30:0]        ee_q;
  logic [39:0]        a0s_q, a1s_q, b0s_q, b1s_q;

  always_comb begin
    e_sum = 52'(ep_q[0]) + 52'(ep_q[1]) + 52'(ep_q[2]);
    e_mag = e_sum[51] ? 52'(-e_sum) : 52'(e_sum);
    e_mag = e_mag + 52'h2_0000;
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      ee_q  <= e_mag[48:18];
      a0s_q <= a0_q * a0_q;
      a1s_q <= a1_q * a1_q;
      b0s_q <= b0_q * b0_q;
      b1s_q <= b1_q * b1_q;
    end
  end

  // stage 5: e^2, squared normal lengths, degenerate flag
  logic [61:0] e2_q;
  logic [40:0] n1_q, n2_q;
  logic [40:0] n1_d, n2_d;
  logic        dg_q;

  assign n1_d = 41'(a0s_q) + 41'(a1s_q);
  assign n2_d = 41'(b0s_q) + 41'(b1s_q);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      e2_q <= ee_q * ee_q;
      n1_q <= n1_d;
      n2_q <= n2_d;
      dg_q <= (n1_d == '0) || (n2_d == '0);
    end
  end

  // stage 6: divider setup; quotient of 16*e2/n overflows 32 bits when e2>>28 >= n
  div_t s6_d, s6_q;

  always_comb begin
    s6_d       = '0;
    s6_d.r1    = 42'(e2_q[61:28]);
    s6_d.r2    = 42'(e2_q[61:28]);
    s6_d.n1    = n1_q;
    s6_d.n2    = n2_q;
    s6_d.dlo   = {e2_q[27:0], 4'b0000};
    s6_d.sat1  = s6_d.r1 >= 42'(n1_q);
    s6_d.sat2  = s6_d.r2 >= 42'(n2_q);
    s6_d.degen = dg_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) s6_q <= s6_d;
  end

  // divider stages
  div_t div_q [DIVS];

  always_ff @(posedge clk_i) begin
    if (adv[6]) div_q[0] <= div_step(s6_q);
    for (int k = 1; k < DIVS; k++) begin
      if (adv[6+k]) div_q[k] <= div_step(div_q[k-1]);
    end
  end

  // output stage: sum of terms, saturation, threshold compare
  logic [31:0]         t1, t2, err;
  logic [32:0]         tsum;
  eeit_pkg::eeit_out_t out_d, out_q;

  always_comb begin
    t1   = div_q[DIVS-1].sat1 ? eeit_pkg::ERR_MAX : div_q[DIVS-1].q1;
    t2   = div_q[DIVS-1].sat2 ? eeit_pkg::ERR_MAX : div_q[DIVS-1].q2;
    tsum = 33'(t1) + 33'(t2);
    if (div_q[DIVS-1].degen || tsum[32]) err = eeit_pkg::ERR_MAX;
    else                                 err = tsum[31:0];
    out_d.epipolar_error = err;
    out_d.is_inlier      = err < thr_q;
    out_d.degenerate     = div_q[DIVS-1].degen;
  end

  always_ff @(posedge clk_i) begin
    if (adv[NST-1]) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

>>> src/eeit_checker.sv
// Checker: port-level assertions for the epipolar error unit, with its bind.
module eeit_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input eeit_pkg::eeit_out_t             out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.epipolar_error == eeit_pkg::ERR_MAX && !out_data_o.is_inlier)
    else $error("degenerate result not saturated");

  a_inlier_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_inlier |->
      out_data_o.epipolar_error != eeit_pkg::ERR_MAX)
    else $error("saturated error flagged inlier");

  // a free output stage always takes input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind epipolar_error_inlier_test_unit eeit_checker u_eeit_checker (.*);

>>> dv/eeit_checker.sv
// Checker: watches the cfg, in and out channels, predicts each epipolar error result and compares.
module eeit_scoreboard (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [eeit_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [eeit_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  eeit_pkg::eeit_in_t                  in_data_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  eeit_pkg::eeit_out_t                 out_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  longint              fm [3][3];
  logic [31:0]         thresh;
  eeit_pkg::eeit_out_t score_q [$];

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned mag_round(longint v, int k);
    longint unsigned u;
    u = (v < 0) ? longint'(-v) : v;
    return (u + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic longint unsigned div_term(longint unsigned e2, longint unsigned n);
    longint unsigned q, r;
    q = e2 / n;
    r = e2 % n;
    if (q >= (64'd1 << 28)) return 64'hFFFF_FFFF;
    return (q << 4) + ((r << 4) / n);
  endfunction

  function automatic eeit_pkg::eeit_out_t score(eeit_pkg::eeit_in_t p);
    longint              a [3], b [3], ln [3], lm [3], e;
    longint unsigned     n1, n2, ee, e2, err, t0, t1;
    eeit_pkg::eeit_out_t o;
    a[0] = sx16(p.first_x);  a[1] = sx16(p.first_y);  a[2] = 4096;
    b[0] = sx16(p.second_x); b[1] = sx16(p.second_y); b[2] = 4096;
    e = 0;
    for (int i = 0; i < 3; i++) begin
      ln[i] = 0;
      lm[i] = 0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        ln[i] += fm[i][j] * a[j];
        lm[j] += fm[i][j] * b[i];
      end
    for (int i = 0; i < 3; i++) e += b[i] * ln[i];
    t0 = mag_round(ln[0], 12); t1 = mag_round(ln[1], 12);
    n1 = t0 * t0 + t1 * t1;
    t0 = mag_round(lm[0], 12); t1 = mag_round(lm[1], 12);
    n2 = t0 * t0 + t1 * t1;
    ee = mag_round(e, 18);
    e2 = ee * ee;
    o.degenerate = (n1 == 0) || (n2 == 0);
    if (o.degenerate) err = 64'hFFFF_FFFF;
    else begin
      err = div_term(e2, n1) + div_term(e2, n2);
      if (err > 64'hFFFF_FFFF) err = 64'hFFFF_FFFF;
    end
    o.epipolar_error = err[31:0];
    o.is_inlier      = (err < thresh);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t MISMATCH %s: got %0h want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = score_q.size();

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    eeit_pkg::eeit_out_t w;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) fm[i][j] = 0;
      thresh = '0;
      score_q.delete();
    end else begin
      // result side first: a result never comes from the item of this same edge
      if (out_valid_i && out_ready_i) begin
        if (score_q.size() == 0) report_mismatch("unexpected result", out_data_i, 0);
        else begin
          w = score_q.pop_front();
          if (out_data_i.epipolar_error !== w.epipolar_error)
            report_mismatch("epipolar_error", out_data_i.epipolar_error, w.epipolar_error);
          if (out_data_i.is_inlier !== w.is_inlier)
            report_mismatch("is_inlier", out_data_i.is_inlier, w.is_inlier);
          if (out_data_i.degenerate !== w.degenerate)
            report_mismatch("degenerate", out_data_i.degenerate, w.degenerate);
        end
      end
      if (in_valid_i && in_ready_i) score_q = {score_q, score(in_data_i)};
      if (cfg_we_i) begin
        if (cfg_idx_i == eeit_pkg::REG_THRESHOLD) thresh = cfg_wdata_i[31:0];
        else
          for (int c = 0; c < 3; c++) fm[cfg_idx_i][c] = sx16(cfg_wdata_i[16*c +: 16]);
      end
    end
  end
endmodule

>>> dv/epipolar_error_inlier_test_unit_tb.sv
// Testbench top: stimulus, configuration phases, flow control and verdict.
module epipolar_error_inlier_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [eeit_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [eeit_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  eeit_pkg::eeit_in_t              in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  eeit_pkg::eeit_out_t             out_data_o;
  int                              fail_count, pending;
  int                              idle_cycles = 0;
  bit                              hold_off = 1'b0;   // long receiver stall requested by stimulus

  epipolar_error_inlier_test_unit DUT (.*);

  eeit_scoreboard u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: own stall pattern, plus a long hold-off counted here
  initial begin
    int mode;
    int stall_len;
    mode = 0;
    stall_len = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_off = 1'b0;
      end
      if (stall_len == 0) begin
        mode = $urandom_range(0, 3);
        stall_len = $urandom_range(1, 40);
      end
      stall_len--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= ($urandom_range(0, 4) != 0);
        default: out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // one transfer on the in channel; valid held until accepted
  task automatic send_item(eeit_pkg::eeit_in_t p);
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  // one register write per edge; the enable stays up across a group of writes
  task automatic write_reg(eeit_pkg::eeit_reg_e idx, logic [eeit_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic end_cfg();
    cfg_we_i <= 1'b0;
  endtask

  // wait for every outstanding result, then keep waiting with no input
  task automatic drain();
    drop_valid();
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick16(int sel);
    case (sel)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h1000;
      4: return 16'hF000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] small_q12();
    return 16'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  // random Q1.14 row, biased to small entries, some extremes
  function automatic logic [47:0] rand_row();
    logic [47:0] r;
    for (int c = 0; c < 3; c++)
      r[16*c +: 16] = ($urandom_range(0, 3) == 0) ? pick16($urandom_range(0, 6))
                                                 : 16'($signed($urandom_range(0, 4095)) - 2048);
    return r;
  endfunction

  task automatic random_burst(int count);
    eeit_pkg::eeit_in_t p;
    int                 burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && count > 0; k++, count--) begin
        if ($urandom_range(0, 3) == 0) begin
          p.first_x = pick16($urandom_range(0, 6)); p.first_y = pick16($urandom_range(0, 6));
          p.second_x = pick16($urandom_range(0, 6)); p.second_y = pick16($urandom_range(0, 6));
        end else begin
          p.first_x = small_q12(); p.first_y = small_q12();
          p.second_x = small_q12(); p.second_y = small_q12();
        end
        send_item(p);
      end
      if ($urandom_range(0, 2) != 0) begin
        drop_valid();
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    eeit_pkg::eeit_in_t p;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero matrix from reset: every item is degenerate
    p = '0;
    send_item(p);
    p = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
    send_item(p);
    drain();

    // identity-like skew matrix (essential of pure x translation), small threshold
    write_reg(eeit_pkg::REG_ROW0, {16'h0000, 16'h0000, 16'h0000});
    write_reg(eeit_pkg::REG_ROW1, {16'hC000, 16'h0000, 16'h0000});
    write_reg(eeit_pkg::REG_ROW2, {16'h0000, 16'h4000, 16'h0000});
    write_reg(eeit_pkg::REG_THRESHOLD, 48'h0000_0000_0100);
    end_cfg();
    p = '{16'h0000, 16'h0000, 16'h0000, 16'h0000}; send_item(p);
    p = '{16'h1000, 16'h0800, 16'h2000, 16'h0800}; send_item(p);   // inlier, zero residual
    p = '{16'h1000, 16'h0800, 16'h2000, 16'h1800}; send_item(p);
    p = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000}; send_item(p);   // large residual, outlier
    p = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF}; send_item(p);
    p = '{16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF}; send_item(p);
    drain();

    // full-scale matrix, maximum threshold
    write_reg(eeit_pkg::REG_ROW0, 48'h8000_7FFF_8000);
    write_reg(eeit_pkg::REG_ROW1, 48'h7FFF_8000_7FFF);
    write_reg(eeit_pkg::REG_ROW2, 48'hFFFF_FFFF_FFFF);
    write_reg(eeit_pkg::REG_THRESHOLD, 48'hFFFF_FFFF_FFFF);  // bits above 32 dropped
    end_cfg();
    for (int k = 0; k < 8; k++) begin
      p = '{pick16(k % 6), pick16((k + 2) % 6), pick16((k + 4) % 6), pick16(k % 5)};
      send_item(p);
    end
    drain();

    // random phases, with one long receiver hold-off to fill the pipeline
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(eeit_pkg::REG_ROW0, rand_row());
      write_reg(eeit_pkg::REG_ROW1, rand_row());
      write_reg(eeit_pkg::REG_ROW2, (ph == 3) ? 48'h0 : rand_row());
      case (ph % 4)
        0: write_reg(eeit_pkg::REG_THRESHOLD, 48'h0);
        1: write_reg(eeit_pkg::REG_THRESHOLD, 48'hFFFF_FFFF);
        default: write_reg(eeit_pkg::REG_THRESHOLD,
                           {16'h0, 32'($urandom_range(0, 32'h0010_0000))});
      endcase
      end_cfg();
      if (ph == 2) hold_off = 1'b1;
      random_burst(100);
      drain();
    end

    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
